// ----- rtl/frame_bottleneck_profiler_defines.svh -----
// Assertion macros for the profiler checker
`ifndef FRAME_BOTTLENECK_PROFILER_DEFINES_SVH
`define FRAME_BOTTLENECK_PROFILER_DEFINES_SVH

`define FBP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define FBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fbp_pkg.sv -----
package fbp_pkg;

    localparam int unsigned KIND_W = 3;
    localparam int unsigned VERD_W = 3;

    localparam logic [2:0] K_RESET     = 3'd0;
    localparam logic [2:0] K_CPU_BEGIN = 3'd1;
    localparam logic [2:0] K_SUBMIT    = 3'd2;
    localparam logic [2:0] K_CPU_END   = 3'd3;
    localparam logic [2:0] K_VU_START  = 3'd4;
    localparam logic [2:0] K_VU_STOP   = 3'd5;
    localparam logic [2:0] K_RASTER    = 3'd6;

    localparam logic [2:0] V_WAITING = 3'd0;
    localparam logic [2:0] V_UNKNOWN = 3'd1;
    localparam logic [2:0] V_CPU     = 3'd2;
    localparam logic [2:0] V_MIXED   = 3'd3;
    localparam logic [2:0] V_RASTER  = 3'd4;
    localparam logic [2:0] V_VU      = 3'd5;

    localparam logic CFG_RANGE = 1'b0;
    localparam logic CFG_SKEW  = 1'b1;

    localparam logic [31:0] RANGE_RESET = 32'd12582912;
    localparam logic [23:0] SKEW_RESET  = 24'd62500;

    // Operands handed to the classifier
    typedef struct packed {
        logic [31:0] vspan;
        logic [31:0] rspan;
        logic [31:0] cpu;
        logic        busy_zero;
        logic [31:0] clk;
        logic [31:0] cmd;
        logic [31:0] pipe;
        logic [31:0] tmem;
        logic [31:0] range_limit;
        logic [23:0] skew;
    } cls_in_t;

endpackage

// ----- rtl/frame_bottleneck_profiler.sv -----
// An event passes through the look-up and execute states to the output
// transaction; an event that finishes a task also runs the classifier before
// the output. The block takes no new event until the output transaction of the
// last one has been taken, so an output stall also holds the input.
// Reset (rst_n low) frees all slots, sets the verdict to waiting and loads the
// register defaults.
module frame_bottleneck_profiler #(
    parameter int unsigned SLOTS        = 3,
    parameter int unsigned COUNTER_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // kind[2:0]
    input  logic [fbp_pkg::KIND_W-1:0] s_tuser,
    // task_tag[31:0], timestamp[63:32], yielded[64], raster_clock[88:65],
    // raster_cmd_busy[112:89], raster_pipe_busy[136:113],
    // raster_tmem_busy[160:137]
    input  logic [167:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // verdict[2:0], verdict_updated[3]
    output logic [7:0]  m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata
);

    localparam int unsigned SW = $clog2(SLOTS);

    typedef enum logic [2:0] { S_IDLE, S_LOOK, S_EXEC, S_CLS, S_OUT } state_t;

    state_t            state_reg;
    logic [31:0]       range_reg;
    logic [23:0]       skew_reg;
    logic [fbp_pkg::KIND_W-1:0] kind_reg;
    logic [160:0]      ev_reg;

    logic [31:0]       task_reg   [SLOTS];
    logic [31:0]       cpu_reg    [SLOTS];
    logic [31:0]       first_reg  [SLOTS];
    logic [31:0]       slice_reg  [SLOTS];
    logic [31:0]       busy_reg   [SLOTS];
    logic [31:0]       vspan_reg  [SLOTS];
    logic [31:0]       rspan_reg  [SLOTS];
    logic [31:0]       ctr_reg    [SLOTS][4];
    logic [4:0]        flags_reg  [SLOTS];

    logic              build_ok_reg;
    logic [SW-1:0]     build_reg;
    logic [31:0]       cpu_start_reg;
    logic              cpu_active_reg;
    logic [2:0]        verdict_reg;
    logic              upd_reg;

    logic              hit_reg;
    logic [SW-1:0]     hit_idx_reg;
    logic              free_ok_reg;
    logic [SW-1:0]     free_idx_reg;
    logic [SW-1:0]     cls_idx_reg;
    logic              cls_start_reg;

    logic              hit_c;
    logic [SW-1:0]     hit_idx_c;
    logic              free_c;
    logic [SW-1:0]     free_idx_c;

    logic [2:0]        e_kind;
    logic [31:0]       e_tag;
    logic [31:0]       e_now;
    logic              e_yield;
    logic [31:0]       e_ctr [4];

    fbp_pkg::cls_in_t  cls_op;
    logic              cls_done;
    logic [2:0]        cls_verdict;

    assign e_kind  = kind_reg;
    assign e_tag   = ev_reg[31:0];
    assign e_now   = ev_reg[63:32];
    assign e_yield = ev_reg[64];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            e_ctr[k] = {8'd0, ev_reg[65 + 24*k +: 24]}
                       & 32'((64'd1 << COUNTER_BITS) - 64'd1);
        end
        hit_c      = 1'b0;
        hit_idx_c  = '0;
        free_c     = 1'b0;
        free_idx_c = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (e_tag != 32'd0 && task_reg[i] == e_tag)
            begin
                hit_c     = 1'b1;
                hit_idx_c = SW'(i);
            end
            if (task_reg[i] == 32'd0)
            begin
                free_c     = 1'b1;
                free_idx_c = SW'(i);
            end
        end
    end

    always_comb
    begin
        cls_op.vspan       = vspan_reg[cls_idx_reg];
        cls_op.rspan       = rspan_reg[cls_idx_reg];
        cls_op.cpu         = cpu_reg[cls_idx_reg];
        cls_op.busy_zero   = (busy_reg[cls_idx_reg] == 32'd0);
        cls_op.clk         = ctr_reg[cls_idx_reg][0];
        cls_op.cmd         = ctr_reg[cls_idx_reg][1];
        cls_op.pipe        = ctr_reg[cls_idx_reg][2];
        cls_op.tmem        = ctr_reg[cls_idx_reg][3];
        cls_op.range_limit = range_reg;
        cls_op.skew        = skew_reg;
    end

    fbp_classifier u_cls (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cls_start_reg),
        .op      (cls_op),
        .done    (cls_done),
        .verdict (cls_verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= fbp_pkg::RANGE_RESET;
            skew_reg  <= fbp_pkg::SKEW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fbp_pkg::CFG_RANGE: range_reg <= cfg_wdata;
                fbp_pkg::CFG_SKEW:  skew_reg  <= cfg_wdata[23:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            build_ok_reg   <= 1'b0;
            build_reg      <= '0;
            cpu_start_reg  <= '0;
            cpu_active_reg <= 1'b0;
            verdict_reg    <= fbp_pkg::V_WAITING;
            upd_reg        <= 1'b0;
            cls_start_reg  <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                task_reg[i]  <= '0;
                flags_reg[i] <= '0;
            end
        end
        else
        begin
            cls_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        kind_reg  <= s_tuser;
                        ev_reg    <= s_tdata[160:0];
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    hit_reg      <= hit_c;
                    hit_idx_reg  <= hit_idx_c;
                    free_ok_reg  <= free_c;
                    free_idx_reg <= free_idx_c;
                    upd_reg      <= 1'b0;
                    state_reg    <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_OUT;
                    unique case (e_kind)
                        fbp_pkg::K_RESET:
                        begin
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                task_reg[i]  <= '0;
                                flags_reg[i] <= '0;
                            end
                            build_ok_reg   <= 1'b0;
                            cpu_active_reg <= 1'b0;
                            verdict_reg    <= fbp_pkg::V_WAITING;
                            upd_reg        <= 1'b1;
                        end
                        fbp_pkg::K_CPU_BEGIN:
                        begin
                            cpu_start_reg  <= e_now;
                            cpu_active_reg <= 1'b1;
                            build_ok_reg   <= 1'b0;
                        end
                        fbp_pkg::K_SUBMIT:
                        begin
                            if (e_tag != 32'd0 && cpu_active_reg && !build_ok_reg
                                && !hit_reg && free_ok_reg)
                            begin
                                task_reg[free_idx_reg]  <= e_tag;
                                cpu_reg[free_idx_reg]   <= '0;
                                first_reg[free_idx_reg] <= '0;
                                slice_reg[free_idx_reg] <= '0;
                                busy_reg[free_idx_reg]  <= '0;
                                vspan_reg[free_idx_reg] <= '0;
                                rspan_reg[free_idx_reg] <= '0;
                                for (int k = 0; k < 4; k++)
                                begin
                                    ctr_reg[free_idx_reg][k] <= '0;
                                end
                                flags_reg[free_idx_reg] <= '0;
                                build_ok_reg <= 1'b1;
                                build_reg    <= free_idx_reg;
                            end
                        end
                        fbp_pkg::K_CPU_END:
                        begin
                            if (cpu_active_reg)
                            begin
                                if (build_ok_reg)
                                begin
                                    cpu_reg[build_reg]      <= e_now - cpu_start_reg;
                                    flags_reg[build_reg][2] <= 1'b1;
                                    if (flags_reg[build_reg][3] && flags_reg[build_reg][4])
                                    begin
                                        cls_idx_reg   <= build_reg;
                                        cls_start_reg <= 1'b1;
                                        state_reg     <= S_CLS;
                                    end
                                end
                                else
                                begin
                                    verdict_reg <= fbp_pkg::V_UNKNOWN;
                                    upd_reg     <= 1'b1;
                                end
                            end
                            build_ok_reg   <= 1'b0;
                            cpu_active_reg <= 1'b0;
                        end
                        fbp_pkg::K_VU_START:
                        begin
                            if (hit_reg && !flags_reg[hit_idx_reg][1]
                                && !flags_reg[hit_idx_reg][3])
                            begin
                                if (!flags_reg[hit_idx_reg][0])
                                begin
                                    first_reg[hit_idx_reg]    <= e_now;
                                    flags_reg[hit_idx_reg][0] <= 1'b1;
                                end
                                slice_reg[hit_idx_reg]    <= e_now;
                                flags_reg[hit_idx_reg][1] <= 1'b1;
                            end
                        end
                        fbp_pkg::K_VU_STOP:
                        begin
                            if (hit_reg && flags_reg[hit_idx_reg][1])
                            begin
                                busy_reg[hit_idx_reg] <= busy_reg[hit_idx_reg]
                                    + (e_now - slice_reg[hit_idx_reg]);
                                flags_reg[hit_idx_reg][1] <= 1'b0;
                                if (!e_yield)
                                begin
                                    vspan_reg[hit_idx_reg] <= e_now - first_reg[hit_idx_reg];
                                    flags_reg[hit_idx_reg][3] <= 1'b1;
                                    if (flags_reg[hit_idx_reg][2] && flags_reg[hit_idx_reg][4])
                                    begin
                                        cls_idx_reg   <= hit_idx_reg;
                                        cls_start_reg <= 1'b1;
                                        state_reg     <= S_CLS;
                                    end
                                end
                            end
                        end
                        fbp_pkg::K_RASTER:
                        begin
                            if (hit_reg && flags_reg[hit_idx_reg][0]
                                && !flags_reg[hit_idx_reg][4])
                            begin
                                rspan_reg[hit_idx_reg] <= e_now - first_reg[hit_idx_reg];
                                for (int k = 0; k < 4; k++)
                                begin
                                    ctr_reg[hit_idx_reg][k] <= e_ctr[k];
                                end
                                flags_reg[hit_idx_reg][4] <= 1'b1;
                                if (flags_reg[hit_idx_reg][2] && flags_reg[hit_idx_reg][3])
                                begin
                                    cls_idx_reg   <= hit_idx_reg;
                                    cls_start_reg <= 1'b1;
                                    state_reg     <= S_CLS;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_CLS:
                begin
                    if (cls_done)
                    begin
                        verdict_reg           <= cls_verdict;
                        upd_reg               <= 1'b1;
                        task_reg[cls_idx_reg] <= '0;
                        state_reg             <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {4'd0, upd_reg, verdict_reg};

endmodule

// ----- rtl/fbp_classifier.sv -----
module fbp_classifier
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  fbp_pkg::cls_in_t    op,
    output logic                done,
    output logic [2:0]          verdict
);

    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
    localparam logic [31:0] RECIP3  = 32'hAAAA_AAAB;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL10, S_CHK1, S_MUL3, S_CHK2, S_SCALE, S_FINAL
    } state_t;

    state_t      state_reg;
    logic        done_reg;
    logic [2:0]  verdict_reg;

    logic [31:0] rcp_reg;
    logic [31:0] mul_a_reg;
    logic [31:0] mul_b_reg;
    logic [28:0] tenth_reg;
    logic [30:0] third_reg;
    logic [33:0] maxclk_reg;
    logic [34:0] upper_reg;
    logic [34:0] lower_reg;

    logic [31:0] rcp_c;
    logic [31:0] lower_c;
    logic [34:0] sum_c;
    logic [63:0] prod_c;
    logic [31:0] rem3_c;

    always_comb
    begin
        rcp_c   = (op.vspan > op.rspan) ? op.vspan : op.rspan;
        lower_c = (op.pipe > op.tmem) ? op.pipe : op.tmem;
        if (op.cmd > lower_c)
        begin
            lower_c = op.cmd;
        end
        sum_c   = {3'd0, op.pipe} + {3'd0, op.tmem} + {3'd0, op.cmd};
        prod_c  = 64'(mul_a_reg) * 64'(mul_b_reg);
        rem3_c  = op.rspan - ({1'b0, third_reg} + {third_reg, 1'b0});
    end

    // One multiplier shared by the reciprocal divisions by ten and by three
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            verdict_reg <= fbp_pkg::V_WAITING;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        rcp_reg <= rcp_c;
                        if (rcp_c == 32'd0 || op.cpu == 32'd0 || op.busy_zero)
                        begin
                            verdict_reg <= fbp_pkg::V_UNKNOWN;
                            done_reg    <= 1'b1;
                        end
                        else
                        begin
                            mul_a_reg <= rcp_c;
                            mul_b_reg <= RECIP10;
                            state_reg <= S_MUL10;
                        end
                    end
                end
                S_MUL10:
                begin
                    tenth_reg <= prod_c[63:35];
                    state_reg <= S_CHK1;
                end
                S_CHK1:
                begin
                    if (op.cpu > rcp_reg && (op.cpu - rcp_reg) > {3'd0, tenth_reg})
                    begin
                        verdict_reg <= fbp_pkg::V_CPU;
                        done_reg    <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                    else if (rcp_reg >= op.range_limit)
                    begin
                        verdict_reg <= fbp_pkg::V_UNKNOWN;
                        done_reg    <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                    else if (op.cpu >= rcp_reg || (rcp_reg - op.cpu) <= {3'd0, tenth_reg})
                    begin
                        verdict_reg <= fbp_pkg::V_MIXED;
                        done_reg    <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        mul_a_reg <= op.rspan;
                        mul_b_reg <= RECIP3;
                        state_reg <= S_MUL3;
                    end
                end
                S_MUL3:
                begin
                    third_reg <= prod_c[63:33];
                    state_reg <= S_CHK2;
                end
                S_CHK2:
                begin
                    maxclk_reg <= {2'd0, op.rspan} + {3'd0, third_reg}
                                  + {33'd0, (rem3_c != 32'd0)} + {10'd0, op.skew};
                    state_reg  <= S_SCALE;
                end
                S_SCALE:
                begin
                    if (op.clk == 32'd0 || {2'd0, op.clk} > maxclk_reg || op.cmd > op.clk
                        || op.pipe > op.clk || op.tmem > op.clk || lower_c == 32'd0)
                    begin
                        verdict_reg <= fbp_pkg::V_UNKNOWN;
                        done_reg    <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        upper_reg <= 35'(({1'b0, sum_c} + {sum_c, 1'b0}) >> 2);
                        lower_reg <= 35'(({2'd0, lower_c} + {1'b0, lower_c, 1'b0}) >> 2);
                        state_reg <= S_FINAL;
                    end
                end
                S_FINAL:
                begin
                    if (lower_reg >= {3'd0, rcp_reg - (rcp_reg >> 2)})
                    begin
                        verdict_reg <= fbp_pkg::V_RASTER;
                    end
                    else if (upper_reg <= {3'd0, rcp_reg >> 1}
                             && op.vspan >= rcp_reg - (rcp_reg >> 2))
                    begin
                        verdict_reg <= fbp_pkg::V_VU;
                    end
                    else
                    begin
                        verdict_reg <= fbp_pkg::V_MIXED;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign verdict = verdict_reg;

endmodule

// ----- rtl/fbp_checker.sv -----
`include "frame_bottleneck_profiler_defines.svh"

module fbp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    `FBP_ASSERT_IMPL(a_one_side, clk, rst_n, m_tvalid, !s_tready, "ready while result pending")
    `FBP_ASSERT_NEXT(a_busy_after_take, clk, rst_n, s_tvalid && s_tready, !s_tready,
                     "accepted twice in a row")
    `FBP_ASSERT_IMPL(a_verdict_range, clk, rst_n, m_tvalid,
                     m_tdata[2:0] <= fbp_pkg::V_VU && m_tdata[7:4] == 4'd0, "bad verdict code")
    `FBP_ASSERT_NEXT(a_reset_event, clk, rst_n,
                     s_tvalid && s_tready && s_tuser == fbp_pkg::K_RESET,
                     !m_tvalid, "result too early")

endmodule

bind frame_bottleneck_profiler fbp_checker u_fbp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
